### sv/fcem_pkg.sv
`default_nettype none

package fcem_pkg;

   localparam int RUN_LIMIT   = 4;
   localparam int RUN_MAX_LEN = 65535;

   localparam logic [15:0] RUN_CAP = (RUN_MAX_LEN < 4) ? 16'd4 : 16'(RUN_MAX_LEN);
   localparam int RUN_CNT_W = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;

   localparam int SEC_W      = 24;
   localparam int SPC_MAX    = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SECTORS_PER_CLUSTER = 2'd0,
      CSR_DATA_BASE           = 2'd1,
      CSR_FAT_BASE            = 2'd2,
      CSR_CLUSTER_LIMIT       = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_FETCH = 1'b0,
      KIND_RUN   = 1'b1
   } kind_type;

   typedef struct packed {
      logic        is_start;
      logic [15:0] cluster_value;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [16:0] fat_sector;
      logic [8:0]  entry_byte_offset;
      logic [23:0] run_base;
      logic [15:0] run_size;
      logic [1:0]  run_number;
      logic        chain_end;
      logic [2:0]  check_flags;
      logic        too_many_runs;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  sectors_per_cluster;
      logic [15:0] data_base;
      logic [15:0] fat_base;
      logic [15:0] cluster_limit;
   } cfg_type;

   typedef struct packed {
      logic [SEC_W-1:0]     run_start;
      logic [15:0]          run_length;
      logic [SEC_W-1:0]     expected_sector;
      logic [RUN_CNT_W-1:0] run_count;
      logic                 chain_active;
      logic                 overflow_seen;
   } state_type;

   typedef struct packed {
      rsp_type    rsp0;
      rsp_type    rsp1;
      logic [1:0] count;
   } step_out_type;

endpackage

`default_nettype wire

### sv/fcem_step.sv
`default_nettype none

module fcem_step (
   input  var fcem_pkg::cfg_type      cfg,
   input  var fcem_pkg::state_type    state_cur,
   input  var fcem_pkg::req_type      req,
   output fcem_pkg::state_type        state_next,
   output fcem_pkg::step_out_type     results
);

   function automatic fcem_pkg::rsp_type make_run(
      input logic [fcem_pkg::SEC_W-1:0]     base,
      input logic [15:0]                    size,
      input logic [fcem_pkg::RUN_CNT_W-1:0] num,
      input logic                           last,
      input logic                           ovf
   );
      fcem_pkg::rsp_type r;
      r                   = '0;
      r.kind              = fcem_pkg::KIND_RUN;
      r.run_base          = base;
      r.run_size          = size;
      r.run_number        = 2'(num);
      r.chain_end         = last;
      r.check_flags       = {size[0], base[0], (base < 24'd4)};
      r.too_many_runs     = ovf;
      return r;
   endfunction

   logic [15:0]                    cl;
   logic [fcem_pkg::SEC_W-1:0]     cl_off;
   logic [fcem_pkg::SEC_W-1:0]     first_sec;
   logic [2:0]                     nsec;
   logic                           is_end;
   logic [fcem_pkg::SEC_W-1:0]     sec;
   logic [fcem_pkg::SEC_W-1:0]     rstart;
   logic [15:0]                    len;
   logic [fcem_pkg::SEC_W-1:0]     exp_sec;
   logic [fcem_pkg::RUN_CNT_W-1:0] cnt;
   logic                           ovf;
   logic                           closed;
   fcem_pkg::rsp_type              close_rsp;
   fcem_pkg::rsp_type              fetch_rsp;

   assign cl     = req.cluster_value;
   assign cl_off = {8'd0, cl} - 24'd2;
   assign is_end = (cl < 16'd2) || (cl >= cfg.cluster_limit);

   always_comb begin
      unique case (cfg.sectors_per_cluster)
         3'd2: begin
            nsec      = 3'd2;
            first_sec = {cl_off[fcem_pkg::SEC_W-2:0], 1'b0} + {8'd0, cfg.data_base};
         end
         3'd4: begin
            nsec      = 3'd4;
            first_sec = {cl_off[fcem_pkg::SEC_W-3:0], 2'b00} + {8'd0, cfg.data_base};
         end
         default: begin
            nsec      = 3'd1;
            first_sec = cl_off + {8'd0, cfg.data_base};
         end
      endcase
   end

   always_comb begin
      rstart    = state_cur.run_start;
      len       = state_cur.run_length;
      exp_sec   = state_cur.expected_sector;
      cnt       = state_cur.run_count;
      ovf       = state_cur.overflow_seen;
      closed    = 1'b0;
      close_rsp = '0;
      sec       = '0;
      if (req.is_start) begin
         rstart  = '0;
         len     = '0;
         exp_sec = '0;
         cnt     = '0;
      end
      for (int s = 0; s < fcem_pkg::SPC_MAX; s++) begin
         if (s < int'(nsec)) begin
            sec = first_sec + fcem_pkg::SEC_W'(s);
            if (len == 16'd0) begin
               rstart = sec;
               len    = 16'd1;
            end else if (len < fcem_pkg::RUN_CAP && sec == exp_sec) begin
               len = len + 16'd1;
            end else begin
               if (int'(cnt) + 1 >= fcem_pkg::RUN_LIMIT) begin
                  ovf = 1'b1;
               end
               closed    = 1'b1;
               close_rsp = make_run(rstart, len, cnt, 1'b0, ovf);
               if (int'(cnt) + 1 < fcem_pkg::RUN_LIMIT) begin
                  cnt = cnt + fcem_pkg::RUN_CNT_W'(1);
               end
               rstart = sec;
               len    = 16'd1;
            end
            exp_sec = sec + 24'd1;
         end
      end
   end

   always_comb begin
      fetch_rsp                   = '0;
      fetch_rsp.kind              = fcem_pkg::KIND_FETCH;
      fetch_rsp.fat_sector        = {1'b0, cfg.fat_base} + {9'd0, cl[15:8]};
      fetch_rsp.entry_byte_offset = {cl[7:0], 1'b0};
      fetch_rsp.too_many_runs     = ovf;
   end

   always_comb begin
      state_next = state_cur;
      results    = '0;
      if (req.is_start || (state_cur.chain_active && !is_end)) begin
         state_next.run_start       = rstart;
         state_next.run_length      = len;
         state_next.expected_sector = exp_sec;
         state_next.run_count       = cnt;
         state_next.overflow_seen   = ovf;
         state_next.chain_active    = 1'b1;
         if (closed) begin
            results.rsp0  = close_rsp;
            results.rsp1  = fetch_rsp;
            results.count = 2'd2;
         end else begin
            results.rsp0  = fetch_rsp;
            results.count = 2'd1;
         end
      end else if (state_cur.chain_active) begin
         results.rsp0  = make_run(state_cur.run_start, state_cur.run_length,
                                  state_cur.run_count, 1'b1, state_cur.overflow_seen);
         results.count = 2'd1;
         state_next.chain_active = 1'b0;
         state_next.run_length   = '0;
      end
   end

endmodule

`default_nettype wire

### sv/fat_chain_extent_mapper.sv
`default_nettype none

// An accepted req beat is registered in s1, then its results go to the queue.
// Throughput: one req beat per cycle while the result queue has room and each
//   item gives at most one result; items that close a run give two rsp beats,
//   so for those the single rsp port limits the rate.
// A 4-entry result queue decouples the two channels.
// Reset (synchronous, active high): chain idle, run state cleared, queue empty,
//   registers at sectors_per_cluster 1, data_base 0, fat_base 0, cluster_limit 2.
module fat_chain_extent_mapper (
   input  var logic                         clock,
   input  var logic                         reset,
   input  var logic                         req_valid,
   output logic                             req_stall,
   input  var fcem_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  var logic                         rsp_stall,
   output fcem_pkg::rsp_type                rsp_data,
   input  var logic                         csr_valid,
   output logic                             csr_ready,
   input  var logic [fcem_pkg::CSR_IDX_W-1:0] csr_index,
   input  var logic [15:0]                  csr_data
);

   fcem_pkg::cfg_type      cfg_ff, cfg_in;
   fcem_pkg::state_type    state_ff, state_in;
   fcem_pkg::step_out_type step_res;
   fcem_pkg::req_type      s1_req_ff, s1_req_in;
   logic                   s1_valid_ff, s1_valid_in;

   fcem_pkg::rsp_type                mem_ff [fcem_pkg::FIFO_DEPTH];
   logic [fcem_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fcem_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fcem_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;

   logic       room;
   logic       s1_adv;
   logic       req_acc;
   logic       pop;
   logic [1:0] push_n;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (fcem_pkg::csr_index_type'(csr_index))
            fcem_pkg::CSR_SECTORS_PER_CLUSTER: cfg_in.sectors_per_cluster = csr_data[2:0];
            fcem_pkg::CSR_DATA_BASE:           cfg_in.data_base           = csr_data;
            fcem_pkg::CSR_FAT_BASE:            cfg_in.fat_base            = csr_data;
            fcem_pkg::CSR_CLUSTER_LIMIT:       cfg_in.cluster_limit       = csr_data;
            default:                           cfg_in                     = cfg_ff;
         endcase
      end
   end

   fcem_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .req        (s1_req_ff),
      .state_next (state_in),
      .results    (step_res)
   );

   assign room      = count_ff <= fcem_pkg::FIFO_CNT_W'(fcem_pkg::FIFO_DEPTH - 2);
   assign s1_adv    = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign req_acc   = req_valid && !req_stall;
   assign push_n    = s1_adv ? step_res.count : 2'd0;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      s1_req_in   = s1_req_ff;
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_req_in   = req_data;
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   assign wr_ptr_in = wr_ptr_ff + fcem_pkg::FIFO_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + fcem_pkg::FIFO_PTR_W'(pop);
   assign count_in  = count_ff + fcem_pkg::FIFO_CNT_W'(push_n) - fcem_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step_res.rsp0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + fcem_pkg::FIFO_PTR_W'(1)] <= step_res.rsp1;
      end
      s1_req_ff <= s1_req_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sectors_per_cluster <= 3'd1;
         cfg_ff.data_base           <= 16'd0;
         cfg_ff.fat_base            <= 16'd0;
         cfg_ff.cluster_limit       <= 16'd2;
         state_ff                   <= '0;
         s1_valid_ff                <= 1'b0;
         wr_ptr_ff                  <= '0;
         rd_ptr_ff                  <= '0;
         count_ff                   <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (s1_adv) begin
            state_ff <= state_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fcem_pkg::FIFO_CNT_W'(fcem_pkg::FIFO_DEPTH))
      else $error("result queue over capacity");

   a_double_push: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2 && !pop) |=> count_ff == $past(count_ff) + fcem_pkg::FIFO_CNT_W'(2))
      else $error("two-result push miscounted");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.overflow_seen |=> state_ff.overflow_seen)
      else $error("overflow flag cleared");

   a_active_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.chain_active |-> state_ff.run_length != 16'd0)
      else $error("active chain without open run");
`endif

endmodule

`default_nettype wire

### sim/tb_fat_chain_extent_mapper.sv
`default_nettype none

module tb_fat_chain_extent_mapper;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   fcem_pkg::req_type       req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   fcem_pkg::rsp_type       rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   fcem_pkg::csr_index_type csr_index = fcem_pkg::CSR_SECTORS_PER_CLUSTER;
   logic [15:0]             csr_data = '0;

   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int chain_limit = 2;

   // predictor copy of the block's registers and chain state
   logic [2:0]  cfg_spc;
   logic [15:0] cfg_data_base;
   logic [15:0] cfg_fat_base;
   logic [15:0] cfg_cluster_limit;
   logic [23:0] run_first;
   logic [15:0] run_len;
   logic [23:0] next_sector;
   int          run_idx;
   logic        chain_on;
   logic        overflow;
   fcem_pkg::rsp_type predicted_beats[$];

   fat_chain_extent_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic fcem_pkg::rsp_type closed_run_beat(input logic end_mark);
      fcem_pkg::rsp_type beat;
      beat = '0;
      beat.kind = fcem_pkg::KIND_RUN;
      beat.run_base = run_first;
      beat.run_size = run_len;
      beat.run_number = run_idx[1:0];
      beat.chain_end = end_mark;
      beat.check_flags = {run_len[0], run_first[0], run_first < 24'd4};
      beat.too_many_runs = overflow;
      return beat;
   endfunction

   task automatic map_cluster_sectors(input logic [15:0] cl);
      int unsigned       spc;
      logic [31:0]       span;
      logic [23:0]       sector;
      fcem_pkg::rsp_type beat;
      spc = (cfg_spc == 3'd2 || cfg_spc == 3'd4) ? cfg_spc : 1;
      span = (({16'd0, cl} - 32'd2) & 32'h00FF_FFFF) * spc + cfg_data_base;
      for (int s = 0; s < spc; s++) begin
         sector = span[23:0] + 24'(s);
         if (run_len == 16'd0) begin
            run_first = sector;
            run_len = 16'd1;
         end else if (run_len < fcem_pkg::RUN_CAP && sector == next_sector) begin
            run_len = run_len + 16'd1;
         end else begin
            if (run_idx + 1 >= fcem_pkg::RUN_LIMIT) begin
               overflow = 1'b1;
            end
            predicted_beats.push_back(closed_run_beat(1'b0));
            if (run_idx + 1 < fcem_pkg::RUN_LIMIT) begin
               run_idx++;
            end
            run_first = sector;
            run_len = 16'd1;
         end
         next_sector = sector + 24'd1;
      end
      beat = '0;
      beat.kind = fcem_pkg::KIND_FETCH;
      beat.fat_sector = {1'b0, cfg_fat_base} + 17'(cl[15:8]);
      beat.entry_byte_offset = {cl[7:0], 1'b0};
      beat.too_many_runs = overflow;
      predicted_beats.push_back(beat);
   endtask

   task automatic map_chain_item(input fcem_pkg::req_type item);
      if (item.is_start) begin
         chain_on = 1'b1;
         run_idx = 0;
         run_len = '0;
         run_first = '0;
         next_sector = '0;
         map_cluster_sectors(item.cluster_value);
      end else if (chain_on) begin
         if (item.cluster_value < 16'd2 || item.cluster_value >= cfg_cluster_limit) begin
            predicted_beats.push_back(closed_run_beat(1'b1));
            chain_on = 1'b0;
            run_len = '0;
         end else begin
            map_cluster_sectors(item.cluster_value);
         end
      end
   endtask

   task automatic check_beat(input fcem_pkg::rsp_type want, input fcem_pkg::rsp_type got);
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, got.kind);
         fail_count++;
      end
      if (got.fat_sector !== want.fat_sector) begin
         $error("fat_sector: expected %0d, actual %0d", want.fat_sector, got.fat_sector);
         fail_count++;
      end
      if (got.entry_byte_offset !== want.entry_byte_offset) begin
         $error("entry_byte_offset: expected %0d, actual %0d",
                want.entry_byte_offset, got.entry_byte_offset);
         fail_count++;
      end
      if (got.run_base !== want.run_base) begin
         $error("run_base: expected %0d, actual %0d", want.run_base, got.run_base);
         fail_count++;
      end
      if (got.run_size !== want.run_size) begin
         $error("run_size: expected %0d, actual %0d", want.run_size, got.run_size);
         fail_count++;
      end
      if (got.run_number !== want.run_number) begin
         $error("run_number: expected %0d, actual %0d", want.run_number, got.run_number);
         fail_count++;
      end
      if (got.chain_end !== want.chain_end) begin
         $error("chain_end: expected %0d, actual %0d", want.chain_end, got.chain_end);
         fail_count++;
      end
      if (got.check_flags !== want.check_flags) begin
         $error("check_flags: expected %0d, actual %0d", want.check_flags, got.check_flags);
         fail_count++;
      end
      if (got.too_many_runs !== want.too_many_runs) begin
         $error("too_many_runs: expected %0d, actual %0d",
                want.too_many_runs, got.too_many_runs);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_spc = 3'd1;
         cfg_data_base = '0;
         cfg_fat_base = '0;
         cfg_cluster_limit = 16'd2;
         run_first = '0;
         run_len = '0;
         next_sector = '0;
         run_idx = 0;
         chain_on = 1'b0;
         overflow = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fcem_pkg::CSR_SECTORS_PER_CLUSTER: cfg_spc = csr_data[2:0];
               fcem_pkg::CSR_DATA_BASE:           cfg_data_base = csr_data;
               fcem_pkg::CSR_FAT_BASE:            cfg_fat_base = csr_data;
               fcem_pkg::CSR_CLUSTER_LIMIT:       cfg_cluster_limit = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            map_chain_item(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_beats.size() == 0) begin
               $error("rsp beat with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               check_beat(predicted_beats.pop_front(), rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic start, input logic [15:0] value);
      fcem_pkg::req_type item;
      item.is_start = start;
      item.cluster_value = value;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid, wait out every predicted beat, then let trailing work finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input fcem_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [2:0] spc, input logic [15:0] data_base,
                             input logic [15:0] fat_base, input logic [15:0] limit_cl);
      settle();
      csr_write(fcem_pkg::CSR_SECTORS_PER_CLUSTER, {13'd0, spc});
      csr_write(fcem_pkg::CSR_DATA_BASE, data_base);
      csr_write(fcem_pkg::CSR_FAT_BASE, fat_base);
      csr_write(fcem_pkg::CSR_CLUSTER_LIMIT, limit_cl);
      csr_valid <= 1'b0;
      chain_limit = limit_cl;
   endtask

   task automatic test_contiguous_chain();
      set_config(3'd1, 16'd100, 16'd10, 16'd1000);
      send_item(1'b1, 16'd2);
      send_item(1'b0, 16'd3);
      send_item(1'b0, 16'd4);
      send_item(1'b0, 16'd1000);
   endtask

   task automatic test_idle_entries();
      send_item(1'b0, 16'd5);
      send_item(1'b0, 16'd0);
   endtask

   task automatic test_cluster_sizes();
      set_config(3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(1'b1, 16'hFFFF);
      send_item(1'b0, 16'hFFFE);
      send_item(1'b0, 16'd0);
      set_config(3'd4, 16'd0, 16'd0, 16'hFFFF);
      send_item(1'b1, 16'd2);
      send_item(1'b0, 16'd3);
      send_item(1'b0, 16'd1);
      set_config(3'd0, 16'd0, 16'd0, 16'hFFFF);
      send_item(1'b1, 16'd0);
      send_item(1'b0, 16'hFFFF);
   endtask

   task automatic test_restart_and_overflow();
      set_config(3'd7, 16'd0, 16'd0, 16'hFFFF);
      send_item(1'b1, 16'd10);
      send_item(1'b1, 16'd20);
      send_item(1'b0, 16'd30);
      send_item(1'b0, 16'd40);
      send_item(1'b0, 16'd50);
      send_item(1'b0, 16'd60);
      send_item(1'b0, 16'd61);
      send_item(1'b0, 16'd0);
      set_config(3'd1, 16'd0, 16'd0, 16'd2);
      send_item(1'b1, 16'd5);
      send_item(1'b0, 16'd3);
   endtask

   function automatic int pick_chain_cluster();
      if (chain_limit > 2 && $urandom_range(99) < 80) begin
         return $urandom_range(2, chain_limit - 1);
      end
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_end_value();
      case ($urandom_range(4))
         0: return 0;
         1: return 1;
         2: return chain_limit;
         3: return 65535;
         default: return $urandom_range(chain_limit, 65535);
      endcase
   endfunction

   task automatic run_chains(input int target);
      int   sent;
      int   cur;
      int   hops;
      int   value;
      logic start;
      logic active;
      sent = 0;
      active = 1'b0;
      while (sent < target) begin
         if ($urandom_range(99) < 85) begin
            cur = pick_chain_cluster();
            send_item(1'b1, 16'(cur));
            sent++;
            active = 1'b1;
            hops = (chain_limit > 2) ? $urandom_range(0, 10) : 0;
            repeat (hops) begin
               if ($urandom_range(99) < 65 && cur + 1 >= 2 && cur + 1 < chain_limit) begin
                  cur = cur + 1;
               end else begin
                  cur = $urandom_range(2, chain_limit - 1);
               end
               send_item(1'b0, 16'(cur));
               sent++;
            end
            if ($urandom_range(99) < 90) begin
               send_item(1'b0, 16'(pick_end_value()));
               sent++;
               active = 1'b0;
            end
         end else begin
            start = ($urandom_range(3) == 0);
            value = $urandom_range(0, 65535);
            send_item(start, 16'(value));
            if (start || active) begin
               sent++;
            end
            if (start) begin
               active = 1'b1;
            end else if (value < 2 || value >= chain_limit) begin
               active = 1'b0;
            end
         end
      end
   endtask

   task automatic test_random_chains();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(3'd1, 16'd0, 16'd0, 16'hFFFF);
            1: set_config(3'd2, 16'($urandom), 16'($urandom), 16'($urandom_range(40, 65535)));
            2: set_config(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: set_config(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                          16'($urandom_range(3, 300)));
            4: set_config(3'd3, 16'($urandom), 16'($urandom), 16'd2);
            default: set_config($urandom_range(1) ? 3'd4 : 3'd2, 16'($urandom),
                                16'($urandom), 16'($urandom_range(1000, 65535)));
         endcase
         if (phase < 2) begin
            send_gap_pct = 28;
            rsp_stall_pct = 47;
         end else if (phase < 4) begin
            send_gap_pct = 47;
            rsp_stall_pct = 28;
         end else begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         run_chains(80);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 28;
      rsp_stall_pct = 47;
      test_contiguous_chain();
      test_idle_entries();
      test_cluster_sizes();
      test_restart_and_overflow();
      test_random_chains();
      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
